/* rtl/pest_pkg.sv */
`default_nettype none
package pest_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int BIT_CNT_W = $clog2(DATA_W);

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SCHED = 2'd1;
  localparam logic [1:0] CMD_UNSCHED = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DUP = 3'd1;
  localparam logic [2:0] ST_END_BEFORE_START = 3'd2;
  localparam logic [2:0] ST_SPACING_RANGE = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] stop;
    logic [DATA_W-1:0] spacing;
  } entry_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_UPDATE,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

/* rtl/pest_if.sv */
`default_nettype none
interface pest_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] block_height;
  logic [31:0] start_block;
  logic [31:0] end_block;
  logic [31:0] spacing;
  logic [31:0] request_id;
  modport source (output valid, cmd, block_height, start_block, end_block, spacing,
                  request_id, input ready);
  modport sink (input valid, cmd, block_height, start_block, end_block, spacing,
                request_id, output ready);
endinterface

interface pest_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] result_id;
  logic        fired;
  logic [31:0] out_spacing;
  logic [31:0] out_start;
  logic [31:0] out_end;
  logic        table_changed;
  modport source (output valid, status, result_id, fired, out_spacing, out_start, out_end,
                  table_changed, input ready);
  modport sink (input valid, status, result_id, fired, out_spacing, out_start, out_end,
                table_changed, output ready);
endinterface
`default_nettype wire

/* rtl/pest_ram.sv */
`default_nettype none
module pest_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]            wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/pest_mod.sv */
`default_nettype none
module pest_mod (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [pest_pkg::DATA_W-1:0] dividend,
  input  wire logic [pest_pkg::DATA_W-1:0] divisor,
  output pest_pkg::mod_res_t            res
);
  import pest_pkg::*;

  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    dvd_r;
  logic [DATA_W-1:0]    dsr_r;
  logic [BIT_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DATA_W:0]      trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, dvd_r[DATA_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DATA_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BIT_CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DATA_W-2:0], 1'b0};
    end
  end

  assign res.done     = done_r;
  assign res.rem_zero = (rem_r == '0);
endmodule
`default_nettype wire

/* rtl/periodic_event_schedule_table.sv */
`default_nettype none
// periodic event schedule table
// in_chan carries one command per transfer: tick at a block height, schedule a
// request (start, end, spacing) or unschedule by id. out_chan returns exactly one
// result per command: status, id, fired flag, entry fields and table_changed.
// entry fields live in one single-port-write ram with a registered read; valid
// bits and the id counter are flip-flops.
// one command is worked at a time. a schedule or unschedule walks the table slot
// by slot, reading each valid slot, and stops early on a match. a tick visits
// every slot, reads and updates each valid one, and an entry whose due test needs
// a remainder also passes through the serial remainder unit.
// the result sits in an output register until taken; a stalled receiver only
// holds the block off taking the next command. synchronous reset empties the
// table and sets the next id to zero; no clearing pass is needed.
module periodic_event_schedule_table (
  input wire logic clk,
  input wire logic rst_n,
  pest_in_if.sink  in_chan,
  pest_out_if.source out_chan
);
  import pest_pkg::*;

  state_t state_r, state_nxt;

  // latched command
  logic [1:0]        cmd_r;
  logic [DATA_W-1:0] h_r, s_r, e_r, sp_r, id_r;

  // scan position and table control state
  logic [CNT_W-1:0]         idx_r;
  logic [IDX_W-1:0]         idx;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [DATA_W-1:0]        next_id_r;

  // current entry under test
  entry_t ent_r;
  logic   due_r;
  logic   hit_r;
  logic   changed_r;
  entry_t win_r;
  logic   win_ok_r;

  // output register
  logic              out_valid_r;
  logic [2:0]        status_r;
  logic [DATA_W-1:0] res_id_r, res_sp_r, res_s_r, res_e_r;
  logic              fired_r, chg_r;

  // ram and remainder unit
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic             mod_start;
  mod_res_t         mod_res;

  // free slot search
  logic [IDX_W-1:0] free_idx;
  logic             free_any;

  // per-entry tick arithmetic
  logic [DATA_W:0]   h_ext, s1_new, e1;
  logic [DATA_W-1:0] s_new;
  logic              rebase, remove;
  entry_t            rd;
  logic              accept;
  logic              sched_bad_order, sched_bad_range;

  assign idx    = idx_r[IDX_W-1:0];
  assign rd     = ram_rdata;
  assign accept = in_chan.valid && in_chan.ready;

  assign in_chan.ready = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // tick update math on the captured entry
  always_comb begin
    h_ext  = {1'b0, h_r};
    rebase = (ent_r.start == '0) && (ent_r.spacing != '0) && (h_r != '0);
    s_new  = rebase ? (h_r - 1'b1) : ent_r.start;
    s1_new = {1'b0, s_new} + 1'b1;
    e1     = {1'b0, ent_r.stop} + 1'b1;
    remove = ((s_new == '0) && (ent_r.spacing == '0)) ||
             ((ent_r.spacing == '0) && (h_ext >= s1_new)) ||
             ((ent_r.stop != '0) && (h_ext >= e1));
  end

  // schedule range checks
  always_comb begin
    sched_bad_order = (e_r != '0) && (s_r > e_r);
    sched_bad_range = (e_r != '0) && (sp_r != '0) &&
                      (({1'b0, s_r} + {1'b0, sp_r}) > {1'b0, e_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.cmd == CMD_TICK || in_chan.cmd == CMD_SCHED ||
              in_chan.cmd == CMD_UNSCHED) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (idx_r == CNT_W'(TABLE_ENTRIES)) begin
          state_nxt = S_FINISH;
        end else if (valid_r[idx]) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (cmd_r)
          CMD_SCHED: begin
            state_nxt = (rd.spacing == sp_r && rd.start == s_r && rd.stop == e_r) ?
                        S_FINISH : S_READ;
          end
          CMD_UNSCHED: begin
            state_nxt = (rd.id == id_r) ? S_FINISH : S_READ;
          end
          default: begin
            if (rd.start != '0 && rd.spacing != '0 &&
                {1'b0, h_r} >= {1'b0, rd.start} + 1'b1) begin
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_UPDATE;
            end
          end
        endcase
      end
      S_DIV: begin
        if (mod_res.done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: state_nxt = S_READ;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ram and unit controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '{id: ent_r.id, start: s_new, stop: ent_r.stop, spacing: ent_r.spacing};
    mod_start = 1'b0;
    case (state_r)
      S_EVAL: begin
        mod_start = (cmd_r == CMD_TICK) && (state_nxt == S_DIV);
      end
      S_UPDATE: begin
        ram_we = rebase;
      end
      S_FINISH: begin
        if (cmd_r == CMD_SCHED && !hit_r && !sched_bad_order && !sched_bad_range &&
            free_any) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = '{id: next_id_r, start: s_r, stop: e_r, spacing: sp_r};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pest_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  pest_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(DATA_W'(h_r - rd.start - 1'b1)),
    .divisor (rd.spacing),
    .res     (mod_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // unknown command answers all zeros at once
      if (state_r == S_IDLE && accept && state_nxt == S_IDLE) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_UPDATE && remove) begin
        valid_r[idx] <= 1'b0;
      end
      if (state_r == S_FINISH) begin
        out_valid_r <= 1'b1;
        if (cmd_r == CMD_SCHED && !hit_r && !sched_bad_order && !sched_bad_range &&
            free_any) begin
          valid_r[free_idx] <= 1'b1;
          next_id_r         <= next_id_r + 1'b1;
        end
        if (cmd_r == CMD_UNSCHED && hit_r) begin
          valid_r[idx] <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r     <= in_chan.cmd;
          h_r       <= in_chan.block_height;
          s_r       <= in_chan.start_block;
          e_r       <= in_chan.end_block;
          sp_r      <= in_chan.spacing;
          id_r      <= in_chan.request_id;
          idx_r     <= '0;
          hit_r     <= 1'b0;
          changed_r <= 1'b0;
          win_ok_r  <= 1'b0;
          status_r  <= ST_OK;
          res_id_r  <= '0;
          fired_r   <= 1'b0;
          res_sp_r  <= '0;
          res_s_r   <= '0;
          res_e_r   <= '0;
          chg_r     <= 1'b0;
        end
      end
      S_READ: begin
        if (idx_r != CNT_W'(TABLE_ENTRIES) && !valid_r[idx]) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      S_EVAL: begin
        ent_r <= rd;
        if (state_nxt == S_FINISH) begin
          hit_r <= 1'b1;
        end else if (cmd_r != CMD_TICK) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd.start == '0) begin
          due_r <= 1'b1;
        end else if (rd.spacing == '0) begin
          due_r <= ({1'b0, h_r} == {1'b0, rd.start} + 1'b1);
        end else begin
          due_r <= 1'b0;
        end
      end
      S_DIV: begin
        if (mod_res.done) begin
          due_r <= mod_res.rem_zero;
        end
      end
      S_UPDATE: begin
        idx_r <= idx_r + 1'b1;
        if (rebase || remove) begin
          changed_r <= 1'b1;
        end
        // strict compare keeps the lowest slot among equal ids
        if (due_r && (!win_ok_r || ent_r.id < win_r.id)) begin
          win_ok_r <= 1'b1;
          win_r    <= '{id: ent_r.id, start: s_new, stop: ent_r.stop,
                        spacing: ent_r.spacing};
        end
      end
      S_FINISH: begin
        case (cmd_r)
          CMD_TICK: begin
            status_r <= ST_OK;
            chg_r    <= changed_r;
            fired_r  <= win_ok_r;
            if (win_ok_r) begin
              res_id_r <= win_r.id;
              res_sp_r <= win_r.spacing;
              res_s_r  <= win_r.start;
              res_e_r  <= win_r.stop;
            end
          end
          CMD_SCHED: begin
            if (hit_r) begin
              status_r <= ST_DUP;
            end else if (sched_bad_order) begin
              status_r <= ST_END_BEFORE_START;
            end else if (sched_bad_range) begin
              status_r <= ST_SPACING_RANGE;
            end else if (!free_any) begin
              status_r <= ST_FULL;
            end else begin
              status_r <= ST_OK;
              res_id_r <= next_id_r;
              res_sp_r <= sp_r;
              res_s_r  <= s_r;
              res_e_r  <= e_r;
              chg_r    <= 1'b1;
            end
          end
          default: begin
            if (hit_r) begin
              status_r <= ST_OK;
              res_id_r <= id_r;
              res_sp_r <= ent_r.spacing;
              res_s_r  <= ent_r.start;
              res_e_r  <= ent_r.stop;
              chg_r    <= 1'b1;
            end else begin
              status_r <= ST_NOT_FOUND;
            end
          end
        endcase
      end
      default: begin
        due_r <= due_r;
      end
    endcase
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.result_id     = res_id_r;
  assign out_chan.fired         = fired_r;
  assign out_chan.out_spacing   = res_sp_r;
  assign out_chan.out_start     = res_s_r;
  assign out_chan.out_end       = res_e_r;
  assign out_chan.table_changed = chg_r;
endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;
  import pest_pkg::*;

  localparam int N = TABLE_ENTRIES;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] height;
    logic [31:0] start;
    logic [31:0] stop;
    logic [31:0] spacing;
    logic [31:0] id;
    bit          drain;   // sender waits until every result is back before offering this
  } command_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] id;
    logic        fired;
    logic [31:0] spacing;
    logic [31:0] start;
    logic [31:0] stop;
    logic        changed;
  } outcome_t;

  logic clk = 0;
  logic rst_n = 0;

  pest_in_if  in_bus();
  pest_out_if out_bus();

  periodic_event_schedule_table dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_bus),
    .out_chan(out_bus)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // shadow copy of the schedule table
  bit          tbl_valid [N];
  logic [31:0] tbl_id [N];
  logic [31:0] tbl_start [N];
  logic [31:0] tbl_stop [N];
  logic [31:0] tbl_spacing [N];
  logic [31:0] tbl_next_id = 0;

  command_t pending_cmds[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int outcomes_seen = 0;
  int cycle_count = 0;

  // generator's rough view of heights and ids, only used to aim stimulus
  logic [31:0] gen_height = 0;
  logic [31:0] gen_ids = 0;

  function automatic void add_cmd(command_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic outcome_t apply_command(command_t c);
    outcome_t r;
    int win;
    int slot;
    logic [32:0] s1;
    logic [32:0] e1;
    bit due;
    r = '{default: '0};
    case (c.cmd)
      CMD_TICK: begin
        win = -1;
        for (int i = 0; i < N; i++) begin
          if (tbl_valid[i]) begin
            s1 = {1'b0, tbl_start[i]} + 33'd1;
            if (tbl_start[i] == 0) due = 1;
            else if (tbl_spacing[i] != 0)
              due = ({1'b0, c.height} >= s1) &&
                    ((({1'b0, c.height} - s1) % {1'b0, tbl_spacing[i]}) == 0);
            else due = ({1'b0, c.height} == s1);
            // as-soon-as-possible recurring entry gets anchored to this height
            if (tbl_start[i] == 0 && tbl_spacing[i] != 0 && c.height != 0) begin
              tbl_start[i] = c.height - 1;
              r.changed = 1;
            end
            // lowest id wins, lowest slot among equal ids
            if (due && (win < 0 || tbl_id[i] < tbl_id[win])) win = i;
          end
        end
        if (win >= 0) begin
          r.id = tbl_id[win];
          r.fired = 1;
          r.spacing = tbl_spacing[win];
          r.start = tbl_start[win];
          r.stop = tbl_stop[win];
        end
        // expiry pass uses the rebased starts
        for (int i = 0; i < N; i++) begin
          if (tbl_valid[i]) begin
            s1 = {1'b0, tbl_start[i]} + 33'd1;
            e1 = {1'b0, tbl_stop[i]} + 33'd1;
            if ((tbl_start[i] == 0 && tbl_spacing[i] == 0) ||
                (tbl_spacing[i] == 0 && {1'b0, c.height} >= s1) ||
                (tbl_stop[i] != 0 && {1'b0, c.height} >= e1)) begin
              tbl_valid[i] = 0;
              r.changed = 1;
            end
          end
        end
      end
      CMD_SCHED: begin
        slot = -1;
        for (int i = 0; i < N; i++)
          if (r.status == ST_OK && tbl_valid[i] && tbl_spacing[i] == c.spacing &&
              tbl_start[i] == c.start && tbl_stop[i] == c.stop)
            r.status = ST_DUP;
        if (r.status == ST_OK && c.stop != 0) begin
          if (c.start > c.stop) r.status = ST_END_BEFORE_START;
          else if (c.spacing != 0 &&
                   ({1'b0, c.start} + {1'b0, c.spacing}) > {1'b0, c.stop})
            r.status = ST_SPACING_RANGE;
        end
        if (r.status == ST_OK) begin
          for (int i = N - 1; i >= 0; i--)
            if (!tbl_valid[i]) slot = i;
          if (slot < 0) r.status = ST_FULL;
          else begin
            tbl_valid[slot] = 1;
            tbl_id[slot] = tbl_next_id;
            tbl_start[slot] = c.start;
            tbl_stop[slot] = c.stop;
            tbl_spacing[slot] = c.spacing;
            r.id = tbl_next_id;
            r.spacing = c.spacing;
            r.start = c.start;
            r.stop = c.stop;
            r.changed = 1;
            tbl_next_id = tbl_next_id + 1;
          end
        end
      end
      CMD_UNSCHED: begin
        slot = -1;
        for (int i = N - 1; i >= 0; i--)
          if (tbl_valid[i] && tbl_id[i] == c.id) slot = i;
        if (slot < 0) r.status = ST_NOT_FOUND;
        else begin
          r.id = c.id;
          r.spacing = tbl_spacing[slot];
          r.start = tbl_start[slot];
          r.stop = tbl_stop[slot];
          r.changed = 1;
          tbl_valid[slot] = 0;
        end
      end
      default: ;  // unknown command: all zeros, nothing changes
    endcase
    return r;
  endfunction

  function automatic command_t make_cmd(logic [1:0] op, logic [31:0] h, logic [31:0] s,
                                        logic [31:0] e, logic [31:0] sp, logic [31:0] id);
    command_t c;
    c.cmd = op;
    c.height = h;
    c.start = s;
    c.stop = e;
    c.spacing = sp;
    c.id = id;
    c.drain = 0;
    return c;
  endfunction

  // random command, mostly well-formed requests around the current height
  function automatic command_t random_cmd();
    command_t c;
    int pick;
    c = make_cmd(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.cmd = CMD_TICK;
      case ($urandom_range(0, 19))
        0: c.height = 0;
        1: c.height = $urandom;
        2: c.height = 32'hffff_ffff;
        default: begin
          gen_height = gen_height + $urandom_range(0, 4);
          c.height = gen_height;
        end
      endcase
    end else if (pick < 75) begin
      c.cmd = CMD_SCHED;
      case ($urandom_range(0, 9))
        0, 1, 2: c.start = 0;
        3: ;  // full random start
        default: c.start = gen_height + $urandom_range(0, 20);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c.spacing = 0;
        4: ;
        default: c.spacing = $urandom_range(1, 10);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: c.stop = 0;
        4: ;
        5: c.stop = c.start + c.spacing;
        default: c.stop = c.start + $urandom_range(0, 60);
      endcase
      // occasionally repeat an earlier shape to provoke duplicates
      if ($urandom_range(0, 9) == 0) begin
        c.start = gen_height;
        c.stop = 0;
        c.spacing = 3;
      end
      gen_ids++;
    end else if (pick < 95) begin
      c.cmd = CMD_UNSCHED;
      if ($urandom_range(0, 4) != 0) c.id = gen_ids - $urandom_range(1, 20);
    end else begin
      c.cmd = $urandom_range(0, 1) ? 2'd3 : CMD_UNSCHED;
    end
    return c;
  endfunction

  // stimulus
  initial begin
    command_t c;
    // one-shot as soon as possible, its duplicate, and the error checks
    add_cmd(make_cmd(CMD_SCHED, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_SCHED, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_SCHED, 0, 10, 5, 0, 0));
    add_cmd(make_cmd(CMD_SCHED, 0, 10, 15, 6, 0));
    add_cmd(make_cmd(CMD_SCHED, 0, 32'hffff_fff0, 32'hffff_ffff,
                     32'hffff_ffff, 0));
    add_cmd(make_cmd(CMD_SCHED, 0, 32'hffff_ffff, 32'hffff_ffff, 0, 0));
    add_cmd(make_cmd(CMD_SCHED, 0, 0, 0, 5, 0));
    add_cmd(make_cmd(CMD_SCHED, 0, 4, 20, 4, 0));
    add_cmd(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_TICK, 5, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_TICK, 9, 0, 0, 0, 0));
    add_cmd(make_cmd(CMD_UNSCHED, 0, 0, 0, 0, 32'hffff_ffff));
    add_cmd(make_cmd(CMD_UNSCHED, 0, 0, 0, 0, 3));
    add_cmd(make_cmd(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff, 32'hffff_ffff));
    // fill the table past its size, then a tick at the top height
    for (int i = 0; i < N + 1; i++)
      add_cmd(make_cmd(CMD_SCHED, 0, 100 + i, 0, 7, 0));
    add_cmd(make_cmd(CMD_TICK, 32'hffff_ffff, 0, 0, 0, 0));
    gen_ids = 25;
    for (int i = 0; i < 1000; i++) begin
      c = random_cmd();
      if (i % 250 == 100) c.drain = 1;
      add_cmd(c);
    end
  end

  // sender
  command_t cur_cmd;
  int send_gap = 0;
  bit stim_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 0;
      in_bus.cmd <= '0;
      in_bus.block_height <= '0;
      in_bus.start_block <= '0;
      in_bus.end_block <= '0;
      in_bus.spacing <= '0;
      in_bus.request_id <= '0;
      send_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_outcomes.insert(expected_outcomes.size(), apply_command(cur_cmd));
      if (in_bus.valid && !in_bus.ready) begin
        // hold the offer
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_bus.valid <= 0;
      end else if (pending_cmds.size() > 0 &&
                   (!pending_cmds[0].drain || expected_outcomes.size() == 0)) begin
        cur_cmd = pending_cmds.pop_front();
        in_bus.valid <= 1;
        in_bus.cmd <= cur_cmd.cmd;
        in_bus.block_height <= cur_cmd.height;
        in_bus.start_block <= cur_cmd.start;
        in_bus.end_block <= cur_cmd.stop;
        in_bus.spacing <= cur_cmd.spacing;
        in_bus.request_id <= cur_cmd.id;
        // stretches with no gaps at all now and then
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else begin
        in_bus.valid <= 0;
        if (pending_cmds.size() == 0) stim_done <= 1;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  int stall_left = 0;

  always @(posedge clk) begin
    outcome_t want;
    int nxt_stall;
    if (!rst_n) begin
      out_bus.ready <= 0;
      stall_left <= 0;
    end else begin
      nxt_stall = stall_left;
      if (out_bus.valid && out_bus.ready) begin
        outcomes_seen++;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d id %0h", $time,
                   out_bus.status, out_bus.result_id);
          errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_bus.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, out_bus.status);
            errors++;
          end
          if (out_bus.result_id !== want.id) begin
            $display("%0t: result_id exp %0h got %0h", $time, want.id, out_bus.result_id);
            errors++;
          end
          if (out_bus.fired !== want.fired) begin
            $display("%0t: fired exp %0b got %0b", $time, want.fired, out_bus.fired);
            errors++;
          end
          if (out_bus.out_spacing !== want.spacing) begin
            $display("%0t: out_spacing exp %0h got %0h", $time, want.spacing,
                     out_bus.out_spacing);
            errors++;
          end
          if (out_bus.out_start !== want.start) begin
            $display("%0t: out_start exp %0h got %0h", $time, want.start, out_bus.out_start);
            errors++;
          end
          if (out_bus.out_end !== want.stop) begin
            $display("%0t: out_end exp %0h got %0h", $time, want.stop, out_bus.out_end);
            errors++;
          end
          if (out_bus.table_changed !== want.changed) begin
            $display("%0t: table_changed exp %0b got %0b", $time, want.changed,
                     out_bus.table_changed);
            errors++;
          end
        end
        if (outcomes_seen == 300) nxt_stall = 3000;
        else nxt_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
      if (nxt_stall > 0) begin
        out_bus.ready <= 0;
        stall_left <= nxt_stall - 1;
      end else begin
        out_bus.ready <= 1;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL periodic_event_schedule_table");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    wait (stim_done);
    wait (expected_outcomes.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) begin
      $display("PASS periodic_event_schedule_table");
    end else begin
      $display("FAIL periodic_event_schedule_table");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/pest_pkg.sv
rtl/pest_if.sv
rtl/pest_ram.sv
rtl/pest_mod.sv
rtl/periodic_event_schedule_table.sv
test/tb.sv
